// ----- rtl/core/uri_component_tagger_top_macros.svh -----
// ----------------------------------------------------------------------------
// URI component tagger assertion macros
// Shorthand for clocked assertions. Each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef URI_COMPONENT_TAGGER_TOP_MACROS_SVH
`define URI_COMPONENT_TAGGER_TOP_MACROS_SVH

// Same-cycle implication.
`define UCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/uct_pkg.sv -----
// ----------------------------------------------------------------------------
// URI component tagger package
// Parse phases, part tags, controller states, command/status bundles and
// the character classification used by the datapath.
// ----------------------------------------------------------------------------
package uct_pkg;

  typedef enum logic [2:0] {
    PH_SCHEME,
    PH_COLON,
    PH_AUTH,
    PH_HOST,
    PH_PORT,
    PH_PATH,
    PH_QUERY,
    PH_FRAG
  } phase_t;

  typedef enum logic [2:0] {
    TAG_SCHEME = 3'd0,
    TAG_USER   = 3'd1,
    TAG_HOST   = 3'd2,
    TAG_PORT   = 3'd3,
    TAG_PATH   = 3'd4,
    TAG_QUERY  = 3'd5,
    TAG_FRAG   = 3'd6,
    TAG_DELIM  = 3'd7
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_FL_DATA
  } state_t;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic rd;
    logic emit_flush;
    logic emit_d0;
    logic emit_d1;
  } uct_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic flush_pend;
    logic d0_pend;
    logic d1_pend;
    logic out_free;
  } uct_sts_t;

  typedef struct packed {
    tag_t   tag;
    phase_t phase;
  } step_t;

  function automatic logic is_letter(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic [6:0] tag_bit(tag_t t);
    logic [6:0] b;
    b = '0;
    if (t != TAG_DELIM) b = 7'(1) << t;
    return b;
  endfunction

  // Tag and next phase for one character once the authority is closed.
  function automatic step_t after_auth(phase_t ph, logic [7:0] c);
    step_t r;
    r.tag   = TAG_FRAG;
    r.phase = PH_FRAG;
    case (ph)
      PH_HOST, PH_PORT: begin
        if ((ph == PH_HOST) && (c == CH_COLON)) begin
          r.tag = TAG_DELIM; r.phase = PH_PORT;
        end else if (c == CH_SLASH) begin
          r.tag = TAG_PATH; r.phase = PH_PATH;
        end else if (c == CH_QUEST) begin
          r.tag = TAG_DELIM; r.phase = PH_QUERY;
        end else if (c == CH_HASH) begin
          r.tag = TAG_DELIM; r.phase = PH_FRAG;
        end else if (ph == PH_HOST) begin
          r.tag = TAG_HOST; r.phase = PH_HOST;
        end else begin
          r.tag = TAG_PORT; r.phase = PH_PORT;
        end
      end
      PH_PATH: begin
        if (c == CH_QUEST) begin
          r.tag = TAG_DELIM; r.phase = PH_QUERY;
        end else if (c == CH_HASH) begin
          r.tag = TAG_DELIM; r.phase = PH_FRAG;
        end else begin
          r.tag = TAG_PATH; r.phase = PH_PATH;
        end
      end
      PH_QUERY: begin
        if (c == CH_HASH) begin
          r.tag = TAG_DELIM; r.phase = PH_FRAG;
        end else begin
          r.tag = TAG_QUERY; r.phase = PH_QUERY;
        end
      end
      default: begin
        r.tag = TAG_FRAG; r.phase = PH_FRAG;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/uct_ctrl.sv -----
// ----------------------------------------------------------------------------
// URI component tagger controller
// Sequences one character: accept, replay of the buffered authority run,
// then up to two direct beats into the output register.
// ----------------------------------------------------------------------------
module uct_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  uct_pkg::uct_sts_t   sts,
  output uct_pkg::uct_cmd_t   cmd
);
  import uct_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (sts.flush_pend) begin
          // fetch the next buffered character
          cmd.rd    = 1'b1;
          state_nxt = ST_FL_DATA;
        end else if (sts.d0_pend) begin
          if (sts.out_free) begin
            cmd.emit_d0 = 1'b1;
            state_nxt   = sts.d1_pend ? ST_BUSY : ST_IDLE;
          end
        end else if (sts.d1_pend) begin
          if (sts.out_free) begin
            cmd.emit_d1 = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FL_DATA: begin
        if (sts.out_free) begin
          cmd.emit_flush = 1'b1;
          state_nxt      = ST_BUSY;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/uct_datapath.sv -----
// ----------------------------------------------------------------------------
// URI component tagger datapath
// Character decode, parse state, authority buffer memory, beat formation,
// validity tracking and the output register.
// ----------------------------------------------------------------------------
`include "uri_component_tagger_top_macros.svh"

module uct_datapath #(
  parameter int AUTH_DEPTH = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_character,
  input  logic                in_last_char,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_char,
  output logic [2:0]          out_part_tag,
  output logic                out_run_end,
  output logic                out_uri_end,
  output logic                out_uri_valid,
  input  uct_pkg::uct_cmd_t   cmd,
  output uct_pkg::uct_sts_t   sts
);
  import uct_pkg::*;

  localparam int CW = $clog2(AUTH_DEPTH + 1);
  localparam int AW = $clog2(AUTH_DEPTH);

  logic [7:0] mem [AUTH_DEPTH];
  logic [7:0] rd_data_r;

  phase_t     phase_r,      phase_nxt;
  logic       pend_r,       pend_nxt;
  logic [CW-1:0] count_r,   count_nxt;
  logic [CW-1:0] idx_r,     idx_nxt;
  logic [6:0] seen_r,       seen_nxt;
  logic       bad_r,        bad_nxt;
  logic       colon_r,      colon_nxt;
  logic       flush_pend_r, flush_pend_nxt;
  logic       d0_pend_r,    d0_pend_nxt;
  logic       d1_pend_r,    d1_pend_nxt;
  logic       user_r,       user_nxt;
  logic       in_port_r,    in_port_nxt;
  logic       last_r,       last_nxt;
  logic [7:0] d0_char_r,    d0_char_nxt;
  tag_t       d0_tag_r,     d0_tag_nxt;
  logic [7:0] d1_char_r,    d1_char_nxt;
  tag_t       d1_tag_r,     d1_tag_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  tag_t       out_tag_r;
  logic       out_run_end_r, out_uri_end_r, out_uri_valid_r;

  logic       wr_en;
  logic       flush_req;
  step_t      aa_cur, aa_path;
  logic       out_free;
  logic       emit_any;
  logic       flush_last;
  logic [7:0] beat_c;
  tag_t       beat_t;
  logic       beat_re, beat_ue, beat_ok;
  logic [6:0] seen_all;

  assign out_free   = !out_valid_r || !out_stall;
  assign emit_any   = cmd.emit_flush || cmd.emit_d0 || cmd.emit_d1;
  assign flush_last = (CW'(idx_r + CW'(1)) == count_r);
  assign aa_cur     = after_auth(phase_r, in_character);
  assign aa_path    = after_auth(PH_PATH, in_character);

  assign sts.flush_pend = flush_pend_r;
  assign sts.d0_pend    = d0_pend_r;
  assign sts.d1_pend    = d1_pend_r;
  assign sts.out_free   = out_free;

  // Beat formation.
  always_comb begin
    beat_c  = d1_char_r;
    beat_t  = d1_tag_r;
    beat_re = 1'b1;
    in_port_nxt = in_port_r;
    if (cmd.emit_flush) begin
      beat_c  = rd_data_r;
      beat_re = flush_last && !d0_pend_r && !d1_pend_r;
      if (user_r) begin
        beat_t = TAG_USER;
      end else if (in_port_r) begin
        beat_t = TAG_PORT;
      end else if (rd_data_r == CH_COLON) begin
        beat_t      = TAG_DELIM;
        in_port_nxt = 1'b1;
      end else begin
        beat_t = TAG_HOST;
      end
    end else if (cmd.emit_d0) begin
      beat_c  = d0_char_r;
      beat_t  = d0_tag_r;
      beat_re = !d1_pend_r;
    end
    if (cmd.accept) in_port_nxt = 1'b0;
    beat_ue  = beat_re && last_r;
    seen_all = seen_r | tag_bit(beat_t);
    beat_ok  = beat_ue && colon_r && seen_all[TAG_SCHEME] && seen_all[TAG_PATH] && !bad_r
               && !((seen_all[TAG_USER] || seen_all[TAG_PORT]) && !seen_all[TAG_HOST]);
  end

  // Decode on accept, bookkeeping on each beat.
  always_comb begin
    phase_nxt      = phase_r;
    pend_nxt       = pend_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    seen_nxt       = seen_r;
    bad_nxt        = bad_r;
    colon_nxt      = colon_r;
    flush_pend_nxt = flush_pend_r;
    d0_pend_nxt    = d0_pend_r;
    d1_pend_nxt    = d1_pend_r;
    user_nxt       = user_r;
    last_nxt       = last_r;
    d0_char_nxt    = d0_char_r;
    d0_tag_nxt     = d0_tag_r;
    d1_char_nxt    = d1_char_r;
    d1_tag_nxt     = d1_tag_r;
    wr_en          = 1'b0;
    flush_req      = 1'b0;

    if (cmd.accept) begin
      d0_pend_nxt = 1'b0;
      d1_pend_nxt = 1'b0;
      d0_char_nxt = in_character;
      d0_tag_nxt  = TAG_DELIM;
      d1_char_nxt = in_character;
      d1_tag_nxt  = TAG_DELIM;
      user_nxt    = 1'b0;
      idx_nxt     = '0;
      last_nxt    = in_last_char;
      case (phase_r)
        PH_SCHEME: begin
          d0_pend_nxt = 1'b1;
          if (in_character == CH_COLON) begin
            colon_nxt = 1'b1;
            phase_nxt = PH_COLON;
          end else begin
            d0_tag_nxt = TAG_SCHEME;
            if (!seen_r[TAG_SCHEME] && !is_letter(in_character)) bad_nxt = 1'b1;
          end
        end
        PH_COLON: begin
          if (pend_r) begin
            // resolve the held slash
            pend_nxt    = 1'b0;
            d0_pend_nxt = 1'b1;
            d1_pend_nxt = 1'b1;
            d0_char_nxt = CH_SLASH;
            if (in_character == CH_SLASH) begin
              phase_nxt = PH_AUTH;
            end else begin
              d0_tag_nxt = TAG_PATH;
              d1_tag_nxt = aa_path.tag;
              phase_nxt  = aa_path.phase;
            end
          end else if ((in_character == CH_SLASH) && !in_last_char) begin
            pend_nxt = 1'b1;
          end else begin
            d0_pend_nxt = 1'b1;
            d0_tag_nxt  = aa_path.tag;
            phase_nxt   = aa_path.phase;
          end
        end
        PH_AUTH: begin
          if (in_character == CH_AT) begin
            flush_req   = 1'b1;
            user_nxt    = 1'b1;
            d0_pend_nxt = 1'b1;
            phase_nxt   = PH_HOST;
          end else if (in_character == CH_SLASH) begin
            flush_req   = 1'b1;
            d0_pend_nxt = 1'b1;
            d0_tag_nxt  = TAG_PATH;
            phase_nxt   = PH_PATH;
          end else if ((in_character == CH_QUEST) || (in_character == CH_HASH)) begin
            flush_req   = 1'b1;
            d0_pend_nxt = 1'b1;
            phase_nxt   = (in_character == CH_QUEST) ? PH_QUERY : PH_FRAG;
          end else begin
            if (count_r < CW'(AUTH_DEPTH)) begin
              wr_en     = 1'b1;
              count_nxt = CW'(count_r + CW'(1));
            end else begin
              // buffer full: drop
              bad_nxt = 1'b1;
            end
            flush_req = in_last_char;
          end
        end
        default: begin
          d0_pend_nxt = 1'b1;
          d0_tag_nxt  = aa_cur.tag;
          phase_nxt   = aa_cur.phase;
        end
      endcase
      flush_pend_nxt = flush_req && (count_nxt != '0);
      if (in_last_char) begin
        phase_nxt = PH_SCHEME;
        pend_nxt  = 1'b0;
      end
    end

    if (cmd.emit_flush) begin
      idx_nxt = CW'(idx_r + CW'(1));
      if (flush_last) begin
        flush_pend_nxt = 1'b0;
        count_nxt      = '0;
      end
    end
    if (cmd.emit_d0) d0_pend_nxt = 1'b0;
    if (cmd.emit_d1) d1_pend_nxt = 1'b0;

    if (emit_any) begin
      seen_nxt = seen_all;
      if (beat_ue) begin
        // verdict given: start the next URI clean
        seen_nxt  = '0;
        bad_nxt   = 1'b0;
        colon_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[AW-1:0]] <= in_character;
    if (cmd.rd) rd_data_r <= mem[idx_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SCHEME;
      pend_r       <= 1'b0;
      count_r      <= '0;
      idx_r        <= '0;
      seen_r       <= '0;
      bad_r        <= 1'b0;
      colon_r      <= 1'b0;
      flush_pend_r <= 1'b0;
      d0_pend_r    <= 1'b0;
      d1_pend_r    <= 1'b0;
      user_r       <= 1'b0;
      in_port_r    <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      pend_r       <= pend_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      seen_r       <= seen_nxt;
      bad_r        <= bad_nxt;
      colon_r      <= colon_nxt;
      flush_pend_r <= flush_pend_nxt;
      d0_pend_r    <= d0_pend_nxt;
      d1_pend_r    <= d1_pend_nxt;
      user_r       <= user_nxt;
      in_port_r    <= in_port_nxt;
      last_r       <= last_nxt;
      if (emit_any) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d0_char_r <= d0_char_nxt;
    d0_tag_r  <= d0_tag_nxt;
    d1_char_r <= d1_char_nxt;
    d1_tag_r  <= d1_tag_nxt;
    if (emit_any) begin
      out_char_r      <= beat_c;
      out_tag_r       <= beat_t;
      out_run_end_r   <= beat_re;
      out_uri_end_r   <= beat_ue;
      out_uri_valid_r <= beat_ok;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_part_tag  = out_tag_r;
  assign out_run_end   = out_run_end_r;
  assign out_uri_end   = out_uri_end_r;
  assign out_uri_valid = out_uri_valid_r;

  `UCT_ASSERT_NOW(a_one_beat, 1'b1, $onehot0({cmd.emit_flush, cmd.emit_d0, cmd.emit_d1}), "two beats in one cycle")
  `UCT_ASSERT_NOW(a_beat_has_room, emit_any, out_free, "beat loaded over an unread result")
  `UCT_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(AUTH_DEPTH), "buffer count past depth")
  `UCT_ASSERT_NOW(a_flush_in_range, cmd.emit_flush || cmd.rd, idx_r < count_r, "flush read beyond fill")
  `UCT_ASSERT_NEXT(a_verdict_clears, emit_any && beat_ue, (seen_r == '0) && !bad_r && !colon_r, "URI state kept after verdict")

endmodule

// ----- rtl/core/uri_component_tagger_top.sv -----
// Sequence: a character is accepted in IDLE; in BUSY any authority flush is
// replayed first, each buffered character read from the authority memory and
// then loaded into the output register from FL_DATA; the direct beats (up to
// two) then load from BUSY. Every load waits while the output register holds
// an unread result, and no new character is accepted until the last beat loads.
// Reset: synchronous, active low; parse state clears at once, buffer is not swept.
// ----------------------------------------------------------------------------
// URI component tagger
// Tags each URI byte as scheme, userinfo, host, port, path, query, fragment
// or delimiter, and gives a validity verdict on the final beat of a URI.
// ----------------------------------------------------------------------------
module uri_component_tagger_top #(
  parameter int AUTH_DEPTH = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_character,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic [2:0] out_part_tag,
  output logic       out_run_end,
  output logic       out_uri_end,
  output logic       out_uri_valid
);
  import uct_pkg::*;

  uct_cmd_t cmd;
  uct_sts_t sts;

  uct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  uct_datapath #(
    .AUTH_DEPTH (AUTH_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_character  (in_character),
    .in_last_char  (in_last_char),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_char      (out_char),
    .out_part_tag  (out_part_tag),
    .out_run_end   (out_run_end),
    .out_uri_end   (out_uri_end),
    .out_uri_valid (out_uri_valid),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ----- test/tb_uri_component_tagger_top.sv -----
// ----------------------------------------------------------------------------
// URI component tagger testbench
// Sends URIs one byte per beat with random gaps and random result stalls.
// A tagging predictor kept here computes the expected tagged bytes, and each
// result beat is checked field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_uri_component_tagger_top;
  timeunit 1ns;
  timeprecision 1ps;

  import uct_pkg::*;

  localparam int         AUTH_DEPTH = 63;
  localparam logic [6:0] NO_COLON   = 7'd127;
  localparam int         QUIET_MAX  = 2000;
  localparam int         LONG_HOLD  = 300;
  localparam int         TAIL       = 200;
  localparam int         ITEMS      = 350;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } uri_byte_t;

  typedef struct {
    logic [7:0] ch;
    tag_t       tag;
    logic       run_end;
    logic       uri_end;
    logic       uri_valid;
  } tagged_char_t;

  logic       clk;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_stall;
  logic [7:0] in_character  = 8'h00;
  logic       in_last_char  = 1'b0;
  logic       out_valid;
  logic       out_stall     = 1'b0;
  logic [7:0] out_char;
  logic [2:0] out_part_tag;
  logic       out_run_end;
  logic       out_uri_end;
  logic       out_uri_valid;

  uri_component_tagger_top #(.AUTH_DEPTH(AUTH_DEPTH)) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_part_tag (out_part_tag),
    .out_run_end  (out_run_end),
    .out_uri_end  (out_uri_end),
    .out_uri_valid(out_uri_valid)
  );

  uri_byte_t    send_q[$];
  logic [7:0]   uri_buf[$];
  tagged_char_t tagged_q[$];
  tagged_char_t step_q[$];

  bit in_taken;
  bit out_taken;
  int err_cnt;
  int sent_n;
  int got_n;
  int uri_n;
  int uri_ok_n;
  int dropped_n;
  int tx_gap;
  bit tx_burst;
  int rx_wait;
  bit rx_burst;
  int hold_left;
  bit hold_done;
  int quiet;

  // Tagger state as seen by the predictor.
  phase_t      ph;
  logic [7:0]  auth_mem [AUTH_DEPTH];
  int unsigned auth_cnt;
  logic [6:0]  colon_at;
  bit          held_slash;
  logic [6:0]  seen;
  int unsigned scheme_len;
  bit          broken;

  task automatic report(string msg);
    err_cnt++;
    $display("MISMATCH: %s", msg);
  endtask

  function automatic void clear_uri_state();
    ph         = PH_SCHEME;
    auth_cnt   = 0;
    colon_at   = NO_COLON;
    held_slash = 1'b0;
    seen       = '0;
    scheme_len = 0;
    broken     = 1'b0;
  endfunction

  function automatic void put(logic [7:0] c, tag_t t);
    tagged_char_t e;
    e.ch        = c;
    e.tag       = t;
    e.run_end   = 1'b0;
    e.uri_end   = 1'b0;
    e.uri_valid = 1'b0;
    step_q.push_back(e);
    if (t != TAG_DELIM) seen[t] = 1'b1;
  endfunction

  // Replay buffered authority bytes as userinfo, or as host[':'port].
  function automatic void flush_authority(bit as_user);
    bit in_port;
    in_port = 1'b0;
    for (int i = 0; i < auth_cnt; i++) begin
      if (as_user) begin
        put(auth_mem[i], TAG_USER);
      end else if (!in_port && auth_mem[i] == CH_COLON) begin
        put(auth_mem[i], TAG_DELIM);
        in_port = 1'b1;
      end else begin
        put(auth_mem[i], in_port ? TAG_PORT : TAG_HOST);
      end
    end
    auth_cnt = 0;
  endfunction

  function automatic void tag_closed(logic [7:0] c);
    case (ph)
      PH_HOST, PH_PORT: begin
        if (ph == PH_HOST && c == CH_COLON) begin
          put(c, TAG_DELIM); ph = PH_PORT;
        end else if (c == CH_SLASH) begin
          put(c, TAG_PATH); ph = PH_PATH;
        end else if (c == CH_QUEST) begin
          put(c, TAG_DELIM); ph = PH_QUERY;
        end else if (c == CH_HASH) begin
          put(c, TAG_DELIM); ph = PH_FRAG;
        end else begin
          put(c, ph == PH_HOST ? TAG_HOST : TAG_PORT);
        end
      end
      PH_PATH: begin
        if (c == CH_QUEST) begin
          put(c, TAG_DELIM); ph = PH_QUERY;
        end else if (c == CH_HASH) begin
          put(c, TAG_DELIM); ph = PH_FRAG;
        end else begin
          put(c, TAG_PATH);
        end
      end
      PH_QUERY: begin
        if (c == CH_HASH) begin
          put(c, TAG_DELIM); ph = PH_FRAG;
        end else begin
          put(c, TAG_QUERY);
        end
      end
      default: begin
        ph = PH_FRAG;
        put(c, TAG_FRAG);
      end
    endcase
  endfunction

  // Work out the tagged bytes caused by one accepted byte.
  function automatic void tag_char(logic [7:0] c, logic last);
    bit alpha;
    bit ok;
    int n;
    step_q.delete();
    case (ph)
      PH_SCHEME: begin
        if (c == CH_COLON) begin
          colon_at = 7'(scheme_len);
          put(c, TAG_DELIM);
          ph = PH_COLON;
        end else begin
          alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
          if (!seen[TAG_SCHEME] && !alpha) broken = 1'b1;
          if (scheme_len < 126) scheme_len++;
          put(c, TAG_SCHEME);
        end
      end
      PH_COLON: begin
        if (held_slash) begin
          held_slash = 1'b0;
          if (c == CH_SLASH) begin
            put(CH_SLASH, TAG_DELIM);
            put(c, TAG_DELIM);
            ph = PH_AUTH;
          end else begin
            put(CH_SLASH, TAG_PATH);
            ph = PH_PATH;
            tag_closed(c);
          end
        end else if (c == CH_SLASH && !last) begin
          held_slash = 1'b1;
        end else begin
          ph = PH_PATH;
          tag_closed(c);
        end
      end
      PH_AUTH: begin
        if (c == CH_AT) begin
          flush_authority(1'b1);
          put(c, TAG_DELIM);
          ph = PH_HOST;
        end else if (c == CH_SLASH) begin
          flush_authority(1'b0);
          put(c, TAG_PATH);
          ph = PH_PATH;
        end else if (c == CH_QUEST || c == CH_HASH) begin
          flush_authority(1'b0);
          put(c, TAG_DELIM);
          ph = (c == CH_QUEST) ? PH_QUERY : PH_FRAG;
        end else begin
          if (auth_cnt < AUTH_DEPTH) begin
            auth_mem[auth_cnt] = c;
            auth_cnt++;
          end else begin
            broken = 1'b1;
            dropped_n++;
          end
          if (last) flush_authority(1'b0);
        end
      end
      default: tag_closed(c);
    endcase

    n = step_q.size();
    if (n > 0) begin
      step_q[n-1].run_end = 1'b1;
      if (last) begin
        ok = colon_at != NO_COLON && colon_at > 0 && seen[TAG_SCHEME] && seen[TAG_PATH]
             && !broken;
        if ((seen[TAG_USER] || seen[TAG_PORT]) && !seen[TAG_HOST]) ok = 1'b0;
        step_q[n-1].uri_end   = 1'b1;
        step_q[n-1].uri_valid = ok;
        uri_n++;
        if (ok) uri_ok_n++;
      end
    end
    foreach (step_q[i]) tagged_q.push_back(step_q[i]);
    if (last) clear_uri_state();
  endfunction

  // Stimulus building.
  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0, 1:    return 8'($urandom_range(8'h61, 8'h7A));
      2:       return 8'($urandom_range(8'h30, 8'h39));
      default: return ($urandom_range(0, 1) == 0) ? 8'h2E : 8'h2D;
    endcase
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) uri_buf.push_back(s[i]);
  endfunction

  function automatic void close_uri(bit drain);
    uri_byte_t b;
    foreach (uri_buf[i]) begin
      b.ch    = uri_buf[i];
      b.last  = (i == uri_buf.size() - 1);
      b.drain = drain && (i == 0);
      send_q.push_back(b);
    end
    uri_buf.delete();
  endfunction

  function automatic void add_random_uri(bit drain);
    int kind;
    kind = $urandom_range(0, 15);
    if (kind < 2) begin
      // noise: a short run of arbitrary bytes
      repeat ($urandom_range(1, 8)) uri_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 7) == 0) uri_buf.push_back(text_byte());
      else uri_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
      repeat ($urandom_range(0, 5)) uri_buf.push_back(text_byte());
      if ($urandom_range(0, 15) != 0) uri_buf.push_back(CH_COLON);
      if ($urandom_range(0, 3) != 0) begin
        uri_buf.push_back(CH_SLASH);
        uri_buf.push_back(CH_SLASH);
        if (kind == 2) begin
          // long authority around the buffer size
          repeat ($urandom_range(60, 70)) uri_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end else begin
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(0, 4)) uri_buf.push_back(text_byte());
            uri_buf.push_back(CH_AT);
          end
          repeat ($urandom_range(0, 5)) uri_buf.push_back(text_byte());
          if ($urandom_range(0, 2) == 0) begin
            uri_buf.push_back(CH_COLON);
            repeat ($urandom_range(0, 4)) uri_buf.push_back(8'($urandom_range(8'h30, 8'h39)));
          end
        end
      end else if ($urandom_range(0, 3) == 0) begin
        uri_buf.push_back(CH_SLASH);
      end
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 1) == 0) uri_buf.push_back(CH_SLASH);
        repeat ($urandom_range(0, 4)) uri_buf.push_back(text_byte());
      end
      if ($urandom_range(0, 2) == 0) begin
        uri_buf.push_back(CH_QUEST);
        repeat ($urandom_range(0, 4)) uri_buf.push_back(text_byte());
      end
      if ($urandom_range(0, 3) == 0) begin
        uri_buf.push_back(CH_HASH);
        repeat ($urandom_range(0, 4)) uri_buf.push_back(text_byte());
      end
    end
    close_uri(drain);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input side: predict on every accepted beat.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      tag_char(in_character, in_last_char);
      void'(send_q.pop_front());
      sent_n++;
    end
  end

  // Sender: hold a stalled beat, otherwise wait out the gap and offer the next.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        if (sent_n % 40 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        tx_gap = tx_burst ? 0 : $urandom_range(0, 7);
      end
      if (in_valid && !in_taken) begin
        // hold
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (send_q.size() > 0 && (!send_q[0].drain || tagged_q.size() == 0)) begin
        in_valid     <= 1'b1;
        in_character <= send_q[0].ch;
        in_last_char <= send_q[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: check every accepted beat against the oldest expectation.
  always @(posedge clk) begin : result_check
    tagged_char_t e;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      got_n++;
      if (tagged_q.size() == 0) begin
        report($sformatf("result %0d (char %h) with nothing expected", got_n, out_char));
      end else begin
        e = tagged_q.pop_front();
        if (out_char !== e.ch)
          report($sformatf("result %0d char %h, want %h", got_n, out_char, e.ch));
        if (out_part_tag !== e.tag)
          report($sformatf("result %0d tag %0d, want %s", got_n, out_part_tag, e.tag.name()));
        if (out_run_end !== e.run_end)
          report($sformatf("result %0d run_end %b, want %b", got_n, out_run_end, e.run_end));
        if (out_uri_end !== e.uri_end)
          report($sformatf("result %0d uri_end %b, want %b", got_n, out_uri_end, e.uri_end));
        if (out_uri_valid !== e.uri_valid)
          report($sformatf("result %0d uri_valid %b, want %b", got_n, out_uri_valid,
                           e.uri_valid));
      end
    end
  end

  // Receiver: random stall after each beat, plus one long hold-off mid-run.
  always @(negedge clk) begin
    if (out_taken) begin
      if (got_n % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
      if (got_n == 150 && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_MAX);
      $display("tb_uri_component_tagger_top NOT OK");
      $finish;
    end
  end

  initial begin
    clear_uri_state();

    // Directed URIs.
    uri_buf.push_back(8'hFF);               // no colon, bad first byte
    close_uri(1'b0);
    add_text(":/");                         // empty scheme, slash ends the URI
    close_uri(1'b0);
    add_text("A:/x");                       // lone slash released as path
    close_uri(1'b0);
    add_text("z://u:@h@:1:2?#");            // userinfo, '@' in host, extra port colons
    uri_buf.push_back(8'h00);
    close_uri(1'b0);

    // Random URIs; the first one waits for the pipe to drain.
    add_random_uri(1'b1);
    while (send_q.size() < ITEMS + 23) add_random_uri($urandom_range(0, 7) == 0);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (send_q.size() != 0) @(posedge clk);
    while (tagged_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("sent %0d bytes in %0d URIs (%0d valid), checked %0d tagged results",
             sent_n, uri_n, uri_ok_n, got_n);
    $display("authority bytes dropped on overflow: %0d; long output hold-off applied: %0d",
             dropped_n, hold_done);
    if (err_cnt == 0) begin
      $display("tb_uri_component_tagger_top OK");
    end else begin
      $display("tb_uri_component_tagger_top NOT OK");
    end
    $finish;
  end

endmodule
